@@ src/isc_pkg.sv @@
// ---------------------------------------------------------------------------
// isc_pkg: shared definitions for the itemset support counter
// Field widths, reset values of the configuration registers, input codes,
// register indexes, controller states and the control bundle that the
// controller broadcasts to the candidate cells.
// ---------------------------------------------------------------------------
package isc_pkg;

	localparam int ITEM_W     = 15;
	localparam int CNT_W      = 32;
	localparam int SIZE_W     = 4;
	localparam int PTR_W      = 4;
	localparam int KIND_W     = 2;
	localparam int CIDX_OUT_W = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam int DEF_MAX_CANDIDATES = 64;
	localparam int DEF_MAX_ITEMS      = 8;

	localparam logic [SIZE_W-1:0] SIZE_RESET    = 4'd2;
	localparam logic [CNT_W-1:0]  MIN_SUP_RESET = 32'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD   = 2'd0,
		KIND_TXN    = 2'd1,
		KIND_REPORT = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ITEMSET_SIZE = 1'b0,
		REG_MIN_SUPPORT  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic load;      // write the item into the selected cell
		logic row_done;  // this load completes the selected cell's row
		logic txn;       // transaction item present
		logic txn_last;  // transaction item ends the transaction
		logic clr_ptr;   // clear all match pointers
		logic clr_all;   // empty the table
		logic shift;     // shift counts one cell toward cell 0
	} cell_ctrl_t;

endpackage

@@ src/isc_cell.sv @@
// ---------------------------------------------------------------------------
// isc_cell: one candidate cell
// Holds one candidate row, its match pointer and its support count. The
// count is handed to the lower neighbor when a report shifts the chain.
// ---------------------------------------------------------------------------
module isc_cell
	import isc_pkg::*;
#(
	parameter int  MAX_ITEMS = DEF_MAX_ITEMS,
	localparam int IPOS_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic              sel,
	input  logic [ITEM_W-1:0] item,
	input  logic [IPOS_W-1:0] pos,
	input  logic [PTR_W-1:0]  size,
	input  logic [CNT_W-1:0]  cnt_in,
	output logic [CNT_W-1:0]  cnt_out
);

	logic [ITEM_W-1:0] items_q [MAX_ITEMS];
	logic [PTR_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              active_q;

	logic              hit;
	logic [PTR_W-1:0]  ptr_nxt;
	logic              full;
	logic              sat;

	// The pointer only indexes the row while it is below the size.
	assign hit     = active_q && (ptr_q < size) && (items_q[ptr_q[IPOS_W-1:0]] == item);
	assign ptr_nxt = ptr_q + PTR_W'(hit);
	assign full    = (ptr_nxt >= size);
	assign sat     = &cnt_q;
	assign cnt_out = cnt_q;

	always_ff @(posedge clk) begin
		if (ctrl.load && sel) begin
			items_q[pos] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ptr_q    <= '0;
			cnt_q    <= '0;
		end else if (ctrl.clr_all) begin
			active_q <= 1'b0;
			ptr_q    <= '0;
			cnt_q    <= '0;
		end else begin
			if (ctrl.load && sel && ctrl.row_done) begin
				active_q <= 1'b1;
			end
			if (ctrl.clr_ptr) begin
				ptr_q <= '0;
			end else if (ctrl.txn && active_q) begin
				ptr_q <= ctrl.txn_last ? '0 : ptr_nxt;
			end
			if (ctrl.shift) begin
				cnt_q <= cnt_in;
			end else if (ctrl.txn && ctrl.txn_last && active_q && full && !sat) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

@@ src/itemset_support_counter.sv @@
// ---------------------------------------------------------------------------
// itemset_support_counter: support counting for one itemset level
// A row of candidate cells matches a transaction stream against the loaded
// candidate itemsets and reports the support count of each candidate.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one beat per command: load a
// candidate item, a transaction item (last ends the transaction), report, or
// clear the table. Every cell compares a transaction item in the same cycle,
// so load and transaction beats are taken one per cycle with no gap while
// no report runs. A report clears the match pointers and then shifts the
// count chain once per loaded candidate, giving one result beat per cycle on
// the output channel (out_valid/out_ready) while the receiver keeps out_ready
// high. The first result appears once the controller is in its report state
// and the output register has loaded cell 0's count. During a report the
// input channel is held off, and no count moves while the output register
// is full and not taken.
// The configuration port (cfg_valid/cfg_ready) is always ready.
// After reset the table is empty, all counts are zero, itemset_size is 2 and
// min_support is 1; no clearing pass is needed.
// ---------------------------------------------------------------------------
module itemset_support_counter
	import isc_pkg::*;
#(
	parameter int MAX_CANDIDATES = DEF_MAX_CANDIDATES,
	parameter int MAX_ITEMS      = DEF_MAX_ITEMS
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [KIND_W-1:0]     kind,
	input  logic [ITEM_W-1:0]     item,
	input  logic                  last,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CIDX_OUT_W-1:0] candidate_index,
	output logic [CNT_W-1:0]      support_count,
	output logic                  frequent,
	output logic                  last_result
);

	localparam int LD_W   = $clog2(MAX_CANDIDATES + 1);
	localparam int CIDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int IPOS_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	// Configuration registers.
	logic [SIZE_W-1:0] size_cfg_q;
	logic [CNT_W-1:0]  min_sup_q;

	// Controller state.
	state_t            state_q;
	state_t            state_nxt;
	logic [LD_W-1:0]   loaded_q;
	logic [PTR_W-1:0]  lpos_q;
	logic [LD_W-1:0]   rem_q;
	logic [CIDX_W-1:0] idx_q;

	// Output register.
	logic              out_valid_q;
	logic [CIDX_W-1:0] cidx_q;
	logic [CNT_W-1:0]  count_q;
	logic              freq_q;
	logic              last_q;

	logic              in_fire;
	logic              report_step;
	kind_t             kind_in;
	logic [PTR_W-1:0]  eff_size;
	logic              table_full;
	logic [PTR_W-1:0]  pos_cl;
	logic [PTR_W-1:0]  pos_nxt;
	logic              row_done;
	cell_ctrl_t        ctrl;

	logic [CNT_W-1:0]  cnt_w [MAX_CANDIDATES+1];
	logic [MAX_CANDIDATES-1:0] sel;

	assign cfg_ready = 1'b1;

	// A size of zero acts as one; a size above the row length acts as the
	// row length.
	always_comb begin
		if (size_cfg_q == '0) begin
			eff_size = PTR_W'(1);
		end else if (PTR_W'(size_cfg_q) > PTR_W'(MAX_ITEMS)) begin
			eff_size = PTR_W'(MAX_ITEMS);
		end else begin
			eff_size = PTR_W'(size_cfg_q);
		end
	end

	assign kind_in    = kind_t'(kind);
	assign in_fire    = in_valid && in_ready;
	assign table_full = (loaded_q == LD_W'(MAX_CANDIDATES));
	assign pos_cl     = (lpos_q >= PTR_W'(MAX_ITEMS)) ? PTR_W'(MAX_ITEMS - 1) : lpos_q;
	assign pos_nxt    = pos_cl + PTR_W'(1);
	// The row is complete as soon as the position reaches the current size.
	assign row_done   = (pos_nxt >= eff_size);

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && kind_in == KIND_REPORT && loaded_q != '0) begin
					state_nxt = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (report_step && rem_q == LD_W'(1)) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		in_ready    = 1'b0;
		report_step = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_REPORT: report_step = !out_valid_q || out_ready;
			default:   in_ready = 1'b0;
		endcase
	end

	always_comb begin
		ctrl          = '0;
		ctrl.load     = in_fire && kind_in == KIND_LOAD && !table_full;
		ctrl.row_done = row_done;
		ctrl.txn      = in_fire && kind_in == KIND_TXN;
		ctrl.txn_last = last;
		ctrl.clr_ptr  = in_fire && kind_in == KIND_REPORT;
		ctrl.clr_all  = in_fire && kind_in == KIND_CLEAR;
		ctrl.shift    = report_step;
	end

	// The cell at the fill position takes the loaded items.
	always_comb begin
		for (int c = 0; c < MAX_CANDIDATES; c++) begin
			sel[c] = (loaded_q == LD_W'(c));
		end
	end

	// The count chain ends in zero, so a full report also clears the counts.
	assign cnt_w[MAX_CANDIDATES] = '0;

	for (genvar c = 0; c < MAX_CANDIDATES; c++) begin : g_cell
		isc_cell #(
			.MAX_ITEMS(MAX_ITEMS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.sel     (sel[c]),
			.item    (item),
			.pos     (pos_cl[IPOS_W-1:0]),
			.size    (eff_size),
			.cnt_in  (cnt_w[c+1]),
			.cnt_out (cnt_w[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_cfg_q <= SIZE_RESET;
			min_sup_q  <= MIN_SUP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ITEMSET_SIZE: size_cfg_q <= cfg_data[SIZE_W-1:0];
				REG_MIN_SUPPORT:  min_sup_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			loaded_q <= '0;
			lpos_q   <= '0;
			rem_q    <= '0;
			idx_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.load) begin
				if (row_done) begin
					loaded_q <= loaded_q + LD_W'(1);
					lpos_q   <= '0;
				end else begin
					lpos_q <= pos_nxt;
				end
			end
			if (ctrl.clr_all) begin
				loaded_q <= '0;
				lpos_q   <= '0;
			end
			if (ctrl.clr_ptr) begin
				rem_q <= loaded_q;
				idx_q <= '0;
			end else if (report_step) begin
				rem_q <= rem_q - LD_W'(1);
				idx_q <= idx_q + CIDX_W'(1);
			end
		end
	end

	// Output register: cell 0 holds the count of the next candidate to report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (report_step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report_step) begin
			cidx_q  <= idx_q;
			count_q <= cnt_w[0];
			freq_q  <= (cnt_w[0] >= min_sup_q);
			last_q  <= (rem_q == LD_W'(1));
		end
	end

	assign out_valid       = out_valid_q;
	assign candidate_index = CIDX_OUT_W'(cidx_q);
	assign support_count   = count_q;
	assign frequent        = freq_q;
	assign last_result     = last_q;

`ifndef SYNTH
	// A result that the receiver does not take stays put with its fields.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(cidx_q) &&
			$stable(count_q) && $stable(freq_q) && $stable(last_q)))
		else $error("pending result changed before it was taken");

	// A running report always has a result left to produce.
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPORT) |-> (rem_q != '0))
		else $error("report running with no results left");

	// The fill count never passes the table capacity.
	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= LD_W'(MAX_CANDIDATES))
		else $error("fill count beyond table capacity");

	// Results are taken in load order within a report.
	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		(report_step && out_valid_q && !last_q) |=> (cidx_q == $past(cidx_q) + CIDX_W'(1)))
		else $error("candidate index out of order");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: self-checking testbench for the itemset support counter
// Loads candidate itemsets, streams transactions and requests reports, while
// a predictor kept inside the bench tracks the candidate table, the match
// pointers and the support counts. Each report beat is checked field by field
// against the oldest predicted result. Sender and receiver idle at random.
// ---------------------------------------------------------------------------
module tb_top;
	import isc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXC   = DEF_MAX_CANDIDATES;
	localparam int MAXI   = DEF_MAX_ITEMS;
	localparam int POOL_N = 12;

	// One report beat as the block presents it.
	typedef struct packed {
		logic [CIDX_OUT_W-1:0] cand_idx;
		logic [CNT_W-1:0]      count;
		logic                  freq;
		logic                  fin;
	} support_result_t;

	// Clock, reset and the block's ports. Every input starts at a known value.
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [KIND_W-1:0]     kind      = '0;
	logic [ITEM_W-1:0]     item      = '0;
	logic                  last      = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [CIDX_OUT_W-1:0] candidate_index;
	logic [CNT_W-1:0]      support_count;
	logic                  frequent;
	logic                  last_result;

	// Predicted state of the block. Two-state types so that the table, pointers
	// and counts start at zero, which is their state after reset.
	bit [ITEM_W-1:0] tbl_item [MAXC][MAXI];
	int unsigned     tbl_len [MAXC];    // entries written in each row
	int unsigned     match_ptr [MAXC];
	bit [CNT_W-1:0]  tally [MAXC];
	int unsigned     rows_loaded = 0;
	int unsigned     fill_pos = 0;
	bit [SIZE_W-1:0] size_cfg = SIZE_RESET;
	bit [CNT_W-1:0]  minsup_cfg = MIN_SUP_RESET;

	// Report beats still to come, oldest first.
	support_result_t results_due [$];

	// Stimulus control shared between the test tasks and the processes.
	int unsigned     tx_idle_pct = 12;
	int unsigned     rx_idle_pct = 57;
	int unsigned     stall_request = 0;
	int unsigned     beats_sent = 0;
	int unsigned     fail_count = 0;
	logic [ITEM_W-1:0] round_pool [POOL_N];
	logic [ITEM_W-1:0] picked [$];

	itemset_support_counter u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.item            (item),
		.last            (last),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.candidate_index (candidate_index),
		.support_count   (support_count),
		.frequent        (frequent),
		.last_result     (last_result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// A generous ceiling: the slowest correct run is far below this.
	initial begin
		#5_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// Itemset size as the block applies it: zero acts as one, anything above
	// the row width acts as the row width.
	function automatic int unsigned eff_size(logic [SIZE_W-1:0] v);
		if (v == 0) begin
			return 1;
		end
		if (v > MAXI) begin
			return MAXI;
		end
		return 32'(v);
	endfunction

	// A size may only be applied if every loaded row has at least that many
	// written entries; otherwise matching would read entries never written.
	function automatic bit size_fits(logic [SIZE_W-1:0] v);
		int unsigned e;
		e = eff_size(v);
		for (int c = 0; c < rows_loaded; c++) begin
			if (tbl_len[c] < e) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Advances the predicted state by one accepted input beat and queues the
	// report beats it causes.
	function automatic void predict_support(logic [KIND_W-1:0] k, logic [ITEM_W-1:0] it,
			logic lst);
		int unsigned sz;
		int unsigned pos;
		int unsigned p;
		support_result_t r;
		sz = eff_size(size_cfg);
		case (k)
			KIND_LOAD: begin
				// Loads into a full table are dropped.
				if (rows_loaded < MAXC) begin
					pos = (fill_pos >= MAXI) ? MAXI - 1 : fill_pos;
					tbl_item[rows_loaded][pos] = it;
					if (pos == 0) begin
						tbl_len[rows_loaded] = 1;
					end else if (pos + 1 > tbl_len[rows_loaded]) begin
						tbl_len[rows_loaded] = pos + 1;
					end
					fill_pos = pos + 1;
					// The row closes once it reaches the size in force now,
					// even if the size was lowered part way through.
					if (fill_pos >= sz) begin
						rows_loaded++;
						fill_pos = 0;
					end
				end
			end
			KIND_TXN: begin
				// In-order subsequence match against every complete row.
				for (int c = 0; c < rows_loaded; c++) begin
					p = match_ptr[c];
					if (p < sz && tbl_item[c][p] == it) begin
						match_ptr[c] = p + 1;
					end
				end
				if (lst) begin
					for (int c = 0; c < rows_loaded; c++) begin
						if (match_ptr[c] >= sz && tally[c] != '1) begin
							tally[c]++;
						end
						match_ptr[c] = 0;
					end
				end
			end
			KIND_REPORT: begin
				for (int c = 0; c < rows_loaded; c++) begin
					r.cand_idx = CIDX_OUT_W'(c);
					r.count    = tally[c];
					r.freq     = (tally[c] >= minsup_cfg);
					r.fin      = (c + 1 == rows_loaded);
					results_due = {results_due, r};
				end
				for (int c = 0; c < MAXC; c++) begin
					tally[c]     = '0;
					match_ptr[c] = 0;
				end
			end
			default: begin
				rows_loaded = 0;
				fill_pos    = 0;
				for (int c = 0; c < MAXC; c++) begin
					tally[c]     = '0;
					match_ptr[c] = 0;
				end
			end
		endcase
	endfunction

	// Picks n distinct pool entries; walking the pool in order keeps them
	// ascending.
	function automatic void pick_sorted(int unsigned n);
		int unsigned left;
		left = n;
		picked.delete();
		for (int i = 0; i < POOL_N; i++) begin
			if (left != 0 && $urandom_range(POOL_N - i - 1) < left) begin
				picked = {picked, round_pool[i]};
				left--;
			end
		end
	endfunction

	// Sends one input beat. The sender may idle first; once valid is raised
	// it stays up with a steady payload until the beat is taken.
	task automatic send_beat(logic [KIND_W-1:0] k, logic [ITEM_W-1:0] it, logic lst);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		item     <= it;
		last     <= lst;
		do begin
			@(posedge clk);
		end while (in_ready !== 1'b1);
		if (!(k == KIND_LOAD && rows_loaded >= MAXC)) begin
			beats_sent++;
		end
		predict_support(k, it, lst);
	endtask

	// Brings the block to rest: no beat offered, every report beat received,
	// and then a wait for any load or transaction beat still in flight.
	task automatic drain();
		in_valid <= 1'b0;
		while (results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Register write; only called while the block is at rest.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do begin
			@(posedge clk);
		end while (cfg_ready !== 1'b1);
		if (idx == REG_ITEMSET_SIZE) begin
			size_cfg = d[SIZE_W-1:0];
		end else begin
			minsup_cfg = d;
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Sets the itemset size, emptying the table first when the loaded rows
	// are too short for it. Upper data bits are random and must be dropped.
	task automatic resize(logic [SIZE_W-1:0] v);
		if (!size_fits(v)) begin
			send_beat(KIND_CLEAR, ITEM_W'($urandom_range(32767)), 1'($urandom_range(1)));
			drain();
		end
		write_reg(REG_ITEMSET_SIZE, ($urandom & ~32'hF) | 32'(v));
	endtask

	// Every command once, with the corner cases of matching: an empty report,
	// stray last flags, out-of-order items, a transaction cut short by a
	// report, and a partial row that stays out of reports until complete.
	task automatic test_directed_commands();
		send_beat(KIND_REPORT, '0, 1'b0);
		send_beat(KIND_LOAD, '0, 1'b1);
		send_beat(KIND_LOAD, '1, 1'b0);
		send_beat(KIND_LOAD, 15'd5, 1'b0);
		send_beat(KIND_LOAD, 15'd9, 1'b0);
		send_beat(KIND_TXN, '0, 1'b0);
		send_beat(KIND_TXN, 15'd5, 1'b0);
		send_beat(KIND_TXN, 15'd9, 1'b0);
		send_beat(KIND_TXN, '1, 1'b1);
		send_beat(KIND_TXN, 15'd9, 1'b0);
		send_beat(KIND_TXN, 15'd5, 1'b1);
		send_beat(KIND_TXN, '0, 1'b0);
		send_beat(KIND_LOAD, 15'd7, 1'b0);
		send_beat(KIND_REPORT, '1, 1'b1);
		send_beat(KIND_TXN, '1, 1'b1);
		send_beat(KIND_LOAD, 15'd8, 1'b0);
		send_beat(KIND_TXN, 15'd7, 1'b0);
		send_beat(KIND_TXN, 15'd8, 1'b1);
		send_beat(KIND_REPORT, '0, 1'b0);
		send_beat(KIND_CLEAR, '1, 1'b1);
		send_beat(KIND_REPORT, '0, 1'b0);
		drain();
	endtask

	// Both registers at their extremes, out-of-range sizes, and a size
	// lowered while a row is half loaded.
	task automatic test_register_extremes();
		write_reg(REG_MIN_SUPPORT, '0);
		resize(4'd0);
		send_beat(KIND_LOAD, 15'd1, 1'b0);
		send_beat(KIND_LOAD, 15'd2, 1'b0);
		send_beat(KIND_LOAD, '1, 1'b0);
		send_beat(KIND_TXN, 15'd2, 1'b0);
		send_beat(KIND_TXN, '1, 1'b1);
		send_beat(KIND_REPORT, '0, 1'b0);
		drain();
		write_reg(REG_MIN_SUPPORT, '1);
		resize(4'd15);
		for (int i = 0; i < MAXI; i++) begin
			send_beat(KIND_LOAD, ITEM_W'(10 + i), 1'b0);
		end
		for (int i = 0; i < MAXI; i++) begin
			send_beat(KIND_TXN, ITEM_W'(10 + i), i == MAXI - 1);
		end
		send_beat(KIND_REPORT, '0, 1'b0);
		drain();
		write_reg(REG_MIN_SUPPORT, 32'd1);
		send_beat(KIND_CLEAR, '0, 1'b0);
		drain();
		resize(4'd4);
		send_beat(KIND_LOAD, 15'd100, 1'b0);
		send_beat(KIND_LOAD, 15'd200, 1'b0);
		send_beat(KIND_LOAD, 15'd300, 1'b0);
		drain();
		resize(4'd2);
		// The next load lands past the new size, so it closes the row.
		send_beat(KIND_LOAD, 15'd400, 1'b0);
		send_beat(KIND_TXN, 15'd100, 1'b0);
		send_beat(KIND_TXN, 15'd200, 1'b1);
		send_beat(KIND_REPORT, '0, 1'b0);
		drain();
	endtask

	// Fills the table past capacity with single-item candidates, then holds
	// the receiver off for a long stretch during a full report while the
	// sender keeps offering beats that the block must refuse.
	task automatic test_full_table_stall();
		logic [ITEM_W-1:0] ids [MAXC];
		logic [ITEM_W-1:0] v;
		send_beat(KIND_CLEAR, '0, 1'b0);
		drain();
		write_reg(REG_MIN_SUPPORT, 32'd1);
		resize(4'd1);
		for (int i = 0; i < MAXC + 6; i++) begin
			v = ITEM_W'($urandom_range(32767));
			if (i < MAXC) begin
				ids[i] = v;
			end
			send_beat(KIND_LOAD, v, 1'($urandom_range(1)));
		end
		send_beat(KIND_TXN, ids[5], 1'b0);
		send_beat(KIND_TXN, ids[20], 1'b0);
		send_beat(KIND_TXN, ids[MAXC - 1], 1'b1);
		stall_request = 300;
		send_beat(KIND_REPORT, '0, 1'b0);
		send_beat(KIND_TXN, ids[0], 1'b1);
		send_beat(KIND_REPORT, '1, 1'b1);
		drain();
	endtask

	// One round of traffic: maybe new registers, maybe a fresh table, some
	// candidates built from a small pool of ids, transactions drawn from the
	// same pool so that matches are common, some noise, and a report.
	task automatic run_round();
		int unsigned sz;
		int unsigned ncand;
		int unsigned v;
		drain();
		case ($urandom_range(7))
			0: write_reg(REG_MIN_SUPPORT, '0);
			1: write_reg(REG_MIN_SUPPORT, '1);
			2: write_reg(REG_MIN_SUPPORT, $urandom);
			3, 4: write_reg(REG_MIN_SUPPORT, $urandom_range(1, 4));
			default: ;
		endcase
		if ($urandom_range(2) == 0) begin
			resize(SIZE_W'($urandom_range(15)));
		end
		if (rows_loaded > 40 || $urandom_range(4) == 0) begin
			send_beat(KIND_CLEAR, ITEM_W'($urandom_range(32767)), 1'($urandom_range(1)));
		end

		// Ascending, distinct pool; sometimes it spans the full id range.
		v = $urandom_range(2000);
		for (int i = 0; i < POOL_N; i++) begin
			round_pool[i] = ITEM_W'(v);
			v += $urandom_range(1, 2500);
		end
		if ($urandom_range(3) == 0) begin
			round_pool[0] = '0;
		end
		if ($urandom_range(3) == 0) begin
			round_pool[POOL_N - 1] = '1;
		end

		sz = eff_size(size_cfg);
		ncand = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
		repeat (ncand) begin
			pick_sorted(sz);
			foreach (picked[i]) begin
				send_beat(KIND_LOAD, picked[i], 1'($urandom_range(1)));
			end
		end
		// Now and then a row is left half loaded.
		if (sz > 1 && $urandom_range(4) == 0) begin
			pick_sorted($urandom_range(1, sz - 1));
			foreach (picked[i]) begin
				send_beat(KIND_LOAD, picked[i], 1'b0);
			end
		end

		repeat ($urandom_range(1, 8)) begin
			picked.delete();
			foreach (round_pool[i]) begin
				if ($urandom_range(3) != 0) begin
					picked = {picked, round_pool[i]};
				end
			end
			if (picked.size() == 0) begin
				picked = {picked, round_pool[$urandom_range(POOL_N - 1)]};
			end
			// A broken transaction arrives in descending order.
			if ($urandom_range(6) == 0) begin
				picked.reverse();
			end
			foreach (picked[i]) begin
				send_beat(KIND_TXN, picked[i], i == picked.size() - 1);
			end
			if ($urandom_range(5) == 0) begin
				send_beat(KIND_TXN, ITEM_W'($urandom_range(32767)), 1'($urandom_range(1)));
			end
		end
		send_beat(KIND_REPORT, ITEM_W'($urandom_range(32767)), 1'($urandom_range(1)));
	endtask

	task automatic test_random_traffic(int unsigned n, int unsigned tx_pct,
			int unsigned rx_pct);
		int unsigned start;
		start = beats_sent;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (beats_sent - start < n) begin
			run_round();
		end
		drain();
	endtask

	// Receiver: random idling, or a counted hold-off when a test asks for one.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_request != 0) begin
				stall_left    = stall_request;
				stall_request = 0;
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Result checker: every report beat taken is compared with the oldest
	// predicted one. Values are sampled at the edge, before any update.
	initial begin
		support_result_t want;
		support_result_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
				got = {candidate_index, support_count, frequent, last_result};
				if (results_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: unexpected report beat idx=%0d count=%0d freq=%b fin=%b",
							$realtime, got.cand_idx, got.count, got.freq, got.fin);
					end
				end else begin
					want = results_due.pop_front();
					if (got.cand_idx !== want.cand_idx || got.count !== want.count ||
							got.freq !== want.freq || got.fin !== want.fin) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch idx %0d/%0d count %0d/%0d freq %b/%b fin %b/%b (expected/actual)",
								$realtime, want.cand_idx, got.cand_idx, want.count, got.count,
								want.freq, got.freq, want.fin, got.fin);
						end
					end
				end
			end
		end
	end

	// Test sequence. Reset is applied once; the sender idles lightly and the
	// receiver heavily at first, then the reverse, then neither idles.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_commands();
		test_register_extremes();
		test_full_table_stall();
		test_random_traffic(50, 12, 57);
		test_random_traffic(50, 57, 12);
		test_random_traffic(50, 0, 0);
		drain();
		if (fail_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
